@@ design/rfho_pkg.sv @@
// Shared constants, codes and packet types of the radial falloff height offset core.
// Used by rfho_sqrt_cell, rfho_div_cell and radial_falloff_height_offset_core.
package rfho_pkg;

  // Sample coordinate width; integer coordinates become Q.4 by a 4-bit shift.
  localparam int COORD_BITS  = 10;
  localparam int POS_BITS    = COORD_BITS + 4;
  localparam int CENTRE_BITS = 14;
  localparam int RADIUS_BITS = 15;
  localparam int AMOUNT_BITS = 9;
  localparam int HEIGHT_BITS = 7;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 15;

  // Signed centre minus position, its square and the sum of both squares.
  localparam int WIDE_BITS  = (POS_BITS > CENTRE_BITS) ? POS_BITS : CENTRE_BITS;
  localparam int DIFF_BITS  = WIDE_BITS + 1;
  localparam int SQ_BITS    = 2 * WIDE_BITS + 1;
  localparam int SQRT_STEPS = (SQ_BITS + 1) / 2;
  localparam int RAD_BITS   = 2 * SQRT_STEPS;
  localparam int REM_BITS   = SQRT_STEPS + 2;
  localparam int CMP_BITS   = (SQRT_STEPS > RADIUS_BITS) ? SQRT_STEPS : RADIUS_BITS;

  // (radius - dist) * |amount| and the long division of that value times 256.
  localparam int MAG_BITS   = AMOUNT_BITS;
  localparam int PROD_BITS  = RADIUS_BITS + AMOUNT_BITS - 1;
  localparam int DIV_STEPS  = AMOUNT_BITS + 8;
  localparam int SUM_BITS   = DIV_STEPS + 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTRE_X = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTRE_Y = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RADIUS   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AMOUNT   = 3'd3;

  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 15'd16;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX   = 7'd127;

  typedef struct packed {
    logic [RAD_BITS-1:0]    rad;
    logic [REM_BITS-1:0]    rem;
    logic [SQRT_STEPS-1:0]  root;
    logic [HEIGHT_BITS-1:0] h;
  } sqrt_pkt_t;

  typedef struct packed {
    logic [DIV_STEPS-1:0]   num;
    logic [RADIUS_BITS-1:0] rem;
    logic [DIV_STEPS-1:0]   quo;
    logic [HEIGHT_BITS-1:0] h;
    logic                   neg;
    logic                   rad_zero;
  } div_pkt_t;

endpackage

@@ design/rfho_sqrt_cell.sv @@
// One digit cell of the square root chain: retires one root bit per beat.
// Depends on rfho_pkg for the packet type and widths.
module rfho_sqrt_cell
  import rfho_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_vld,
  input  sqrt_pkt_t in_pkt,
  output logic      out_vld,
  output sqrt_pkt_t out_pkt
);

  logic [REM_BITS+1:0] rem_shift;
  logic [REM_BITS+1:0] trial;
  logic                take;
  sqrt_pkt_t           pkt_next;

  // Bring down the next two radicand bits and try root*4+1.
  assign rem_shift = {in_pkt.rem, in_pkt.rad[RAD_BITS-1 -: 2]};
  assign trial     = (REM_BITS+2)'({in_pkt.root, 2'b01});
  assign take      = (rem_shift >= trial);

  always_comb begin
    pkt_next      = in_pkt;
    pkt_next.rad  = {in_pkt.rad[RAD_BITS-3:0], 2'b00};
    pkt_next.rem  = take ? REM_BITS'(rem_shift - trial) : REM_BITS'(rem_shift);
    pkt_next.root = {in_pkt.root[SQRT_STEPS-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_pkt <= pkt_next;
  end

endmodule

@@ design/rfho_div_cell.sv @@
// One restoring division cell: retires one quotient bit per beat.
// Depends on rfho_pkg for the packet type and widths.
module rfho_div_cell
  import rfho_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic [RADIUS_BITS-1:0] radius,
  input  logic                   in_vld,
  input  div_pkt_t               in_pkt,
  output logic                   out_vld,
  output div_pkt_t               out_pkt
);

  logic [RADIUS_BITS:0] part;
  logic [RADIUS_BITS:0] den;
  logic                 take;
  div_pkt_t             pkt_next;

  assign part = {in_pkt.rem, in_pkt.num[DIV_STEPS-1]};
  assign den  = {1'b0, radius};
  assign take = (part >= den);

  always_comb begin
    pkt_next     = in_pkt;
    pkt_next.num = {in_pkt.num[DIV_STEPS-2:0], 1'b0};
    pkt_next.rem = take ? RADIUS_BITS'(part - den) : RADIUS_BITS'(part);
    pkt_next.quo = {in_pkt.quo[DIV_STEPS-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_pkt <= pkt_next;
  end

endmodule

@@ design/radial_falloff_height_offset_core.sv @@
// Top level of the radial falloff height offset core: config registers, squaring
// front end, square root and divider cell chains, final add and clamp.
// Depends on rfho_pkg, rfho_sqrt_cell and rfho_div_cell.
//
//   channel   handshake                 payload
//   sample    start / busy              pos_x, pos_y, height_in
//   result    done (one-cycle strobe)   height_out
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A sample is taken in every cycle that start is high outside reset; its result
// strobes after 2 squaring stages, one cell per root bit, one scale stage, one
// cell per quotient bit and one output stage.
// busy is high only during reset, which empties the chains.
// The receiver cannot stall, so nothing in the chains ever holds.
module radial_falloff_height_offset_core
  import rfho_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [COORD_BITS-1:0]     pos_x,
  input  logic [COORD_BITS-1:0]     pos_y,
  input  logic [HEIGHT_BITS-1:0]    height_in,
  output logic                      done,
  output logic [HEIGHT_BITS-1:0]    height_out,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int LATENCY = SQRT_STEPS + DIV_STEPS + 4;

  logic [CENTRE_BITS-1:0]        centre_x_q4;
  logic [CENTRE_BITS-1:0]        centre_y_q4;
  logic [RADIUS_BITS-1:0]        radius_q4;
  logic signed [AMOUNT_BITS-1:0] amount;

  logic accept;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x_q4 <= '0;
      centre_y_q4 <= '0;
      radius_q4   <= RADIUS_RESET;
      amount      <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTRE_X: centre_x_q4 <= cfg_data[CENTRE_BITS-1:0];
        REG_CENTRE_Y: centre_y_q4 <= cfg_data[CENTRE_BITS-1:0];
        REG_RADIUS:   radius_q4   <= cfg_data[RADIUS_BITS-1:0];
        REG_AMOUNT:   amount      <= cfg_data[AMOUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: Q.4 differences and their squares.
  logic signed [DIFF_BITS-1:0]   dx;
  logic signed [DIFF_BITS-1:0]   dy;
  logic signed [2*DIFF_BITS-1:0] dx_sq_full;
  logic signed [2*DIFF_BITS-1:0] dy_sq_full;
  logic                          s1_vld;
  logic [SQ_BITS-2:0]            s1_dx_sq;
  logic [SQ_BITS-2:0]            s1_dy_sq;
  logic [HEIGHT_BITS-1:0]        s1_h;

  assign dx = DIFF_BITS'(centre_x_q4) - DIFF_BITS'({pos_x, 4'b0000});
  assign dy = DIFF_BITS'(centre_y_q4) - DIFF_BITS'({pos_y, 4'b0000});
  assign dx_sq_full = dx * dx;
  assign dy_sq_full = dy * dy;

  // Stage 2: sum of squares, the radicand.
  logic               s2_vld;
  logic [SQ_BITS-1:0] s2_sq;
  logic [HEIGHT_BITS-1:0] s2_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= accept;
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_dx_sq <= dx_sq_full[SQ_BITS-2:0];
    s1_dy_sq <= dy_sq_full[SQ_BITS-2:0];
    s1_h     <= height_in;
    s2_sq    <= SQ_BITS'(s1_dx_sq) + SQ_BITS'(s1_dy_sq);
    s2_h     <= s1_h;
  end

  // Square root chain.
  logic      sq_vld [0:SQRT_STEPS];
  sqrt_pkt_t sq_pkt [0:SQRT_STEPS];

  assign sq_vld[0]      = s2_vld;
  assign sq_pkt[0].rad  = RAD_BITS'(s2_sq);
  assign sq_pkt[0].rem  = '0;
  assign sq_pkt[0].root = '0;
  assign sq_pkt[0].h    = s2_h;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    rfho_sqrt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .in_vld  (sq_vld[i]),
      .in_pkt  (sq_pkt[i]),
      .out_vld (sq_vld[i+1]),
      .out_pkt (sq_pkt[i+1])
    );
  end

  // Scale stage: clamp distance at the radius, then (radius - dist) * |amount|.
  logic [CMP_BITS-1:0]    root_ext;
  logic [CMP_BITS-1:0]    radius_ext;
  logic [RADIUS_BITS-1:0] dist_c;
  logic [RADIUS_BITS-1:0] span;
  logic [MAG_BITS-1:0]    amt_mag;
  logic [RADIUS_BITS+MAG_BITS-1:0] prod_full;
  logic                   mid_vld;
  logic [PROD_BITS-1:0]   mid_prod;
  logic [HEIGHT_BITS-1:0] mid_h;
  logic                   mid_neg;
  logic                   mid_rad_zero;

  assign root_ext   = CMP_BITS'(sq_pkt[SQRT_STEPS].root);
  assign radius_ext = CMP_BITS'(radius_q4);
  assign dist_c     = (root_ext > radius_ext) ? radius_q4 : root_ext[RADIUS_BITS-1:0];
  assign span       = radius_q4 - dist_c;
  // The most negative amount maps to a magnitude of 256, which still fits.
  assign amt_mag    = amount[AMOUNT_BITS-1] ? MAG_BITS'(-amount) : MAG_BITS'(amount);
  assign prod_full  = span * amt_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_vld <= 1'b0;
    end else begin
      mid_vld <= sq_vld[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    mid_prod     <= prod_full[PROD_BITS-1:0];
    mid_h        <= sq_pkt[SQRT_STEPS].h;
    mid_neg      <= amount[AMOUNT_BITS-1];
    mid_rad_zero <= (radius_q4 == '0);
  end

  // Divider chain on prod * 256. The quotient never exceeds 256 * |amount|, so
  // the upper dividend bits already sit below the radius and seed the remainder.
  logic     dv_vld [0:DIV_STEPS];
  div_pkt_t dv_pkt [0:DIV_STEPS];

  assign dv_vld[0]          = mid_vld;
  assign dv_pkt[0].num      = {mid_prod[DIV_STEPS-9:0], 8'h00};
  assign dv_pkt[0].rem      = RADIUS_BITS'(mid_prod[PROD_BITS-1:DIV_STEPS-8]);
  assign dv_pkt[0].quo      = '0;
  assign dv_pkt[0].h        = mid_h;
  assign dv_pkt[0].neg      = mid_neg;
  assign dv_pkt[0].rad_zero = mid_rad_zero;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    rfho_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .radius  (radius_q4),
      .in_vld  (dv_vld[i]),
      .in_pkt  (dv_pkt[i]),
      .out_vld (dv_vld[i+1]),
      .out_pkt (dv_pkt[i+1])
    );
  end

  // Output stage: signed offset, add to height in Q.8, truncate and clamp.
  logic signed [SUM_BITS-1:0] offset_q8;
  logic signed [SUM_BITS-1:0] sum_q8;
  logic [HEIGHT_BITS-1:0]     height_next;

  always_comb begin
    if (dv_pkt[DIV_STEPS].rad_zero) begin
      offset_q8 = '0;
    end else if (dv_pkt[DIV_STEPS].neg) begin
      offset_q8 = -SUM_BITS'(dv_pkt[DIV_STEPS].quo);
    end else begin
      offset_q8 = SUM_BITS'(dv_pkt[DIV_STEPS].quo);
    end
    sum_q8 = SUM_BITS'({dv_pkt[DIV_STEPS].h, 8'h00}) + offset_q8;
    if (sum_q8[SUM_BITS-1]) begin
      height_next = '0;
    end else if (sum_q8[SUM_BITS-2:8] > (SUM_BITS-9)'(HEIGHT_MAX)) begin
      height_next = HEIGHT_MAX;
    end else begin
      height_next = sum_q8[HEIGHT_BITS+7:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    height_out <= height_next;
  end

  // Every accepted sample strobes exactly once, a fixed latency later.
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted sample did not strobe at the expected latency");

  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result strobe without a matching accepted sample");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

endmodule

@@ tb/radial_falloff_height_offset_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for radial_falloff_height_offset_core: directed and random
// samples under several falloff settings, each result checked against a local predictor.
// Depends on rfho_pkg and the radial_falloff_height_offset_core RTL.
module radial_falloff_height_offset_core_tb;
  import rfho_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PIPE_LATENCY   = 36;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_SAMPLES  = 110;
  localparam int COORD_MAX      = (1 << COORD_BITS) - 1;

  typedef struct {
    logic [COORD_BITS-1:0]  x;
    logic [COORD_BITS-1:0]  y;
    logic [HEIGHT_BITS-1:0] h;
    logic [HEIGHT_BITS-1:0] height;
  } height_expect_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic [COORD_BITS-1:0]     pos_x = '0;
  logic [COORD_BITS-1:0]     pos_y = '0;
  logic [HEIGHT_BITS-1:0]    height_in = '0;
  logic                      done;
  logic [HEIGHT_BITS-1:0]    height_out;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  // Local copy of the falloff registers, updated on each accepted write beat.
  logic [CENTRE_BITS-1:0]        centre_x = '0;
  logic [CENTRE_BITS-1:0]        centre_y = '0;
  logic [RADIUS_BITS-1:0]        radius = RADIUS_RESET;
  logic signed [AMOUNT_BITS-1:0] amount = '0;

  height_expect_t pending_heights[$];
  bit allow_gaps = 1'b1;
  int error_count = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int settings_used = 0;
  int idle_cycles = 0;

  radial_falloff_height_offset_core dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .height_in  (height_in),
    .done       (done),
    .height_out (height_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = '0;
    for (int b = 20; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic [HEIGHT_BITS-1:0] falloff_height(
    input logic [COORD_BITS-1:0]  x,
    input logic [COORD_BITS-1:0]  y,
    input logic [HEIGHT_BITS-1:0] h
  );
    longint cx, cy, px, py, dx, dy, distance, r, a, hl, offset, sum;
    cx = centre_x;
    cy = centre_y;
    px = x;
    py = y;
    r = radius;
    a = amount;
    hl = h;
    dx = cx - px * 16;
    dy = cy - py * 16;
    distance = int_sqrt(dx * dx + dy * dy);
    if (distance > r) distance = r;
    offset = 0;
    // Signed division truncates toward zero; a zero radius leaves the height alone.
    if (r != 0) offset = (r - distance) * a * 256 / r;
    sum = hl * 256 + offset;
    if (sum < 0) return '0;
    sum = sum >>> 8;
    if (sum > HEIGHT_MAX) return HEIGHT_MAX;
    return sum[HEIGHT_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] near_coord(input logic [CENTRE_BITS-1:0] c);
    int span;
    int p;
    span = int'(radius >> 4) + 2;
    p = int'(c >> 4) - span + int'($urandom_range(2 * span));
    if (p < 0) p = 0;
    if (p > COORD_MAX) p = COORD_MAX;
    return p[COORD_BITS-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic send_sample(
    input logic [COORD_BITS-1:0]  x,
    input logic [COORD_BITS-1:0]  y,
    input logic [HEIGHT_BITS-1:0] h
  );
    height_expect_t item;
    while (allow_gaps && $urandom_range(99) < 22) begin
      @(negedge clk);
      start <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    pos_x <= x;
    pos_y <= y;
    height_in <= h;
    item.x = x;
    item.y = y;
    item.h = h;
    item.height = falloff_height(x, y, h);
    do @(posedge clk); while (busy);
    pending_heights.push_back(item);
    samples_sent++;
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    start <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
  endtask

  // Callers make sure the pipeline is empty before writing.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_CENTRE_X: centre_x = data[CENTRE_BITS-1:0];
      REG_CENTRE_Y: centre_y = data[CENTRE_BITS-1:0];
      REG_RADIUS:   radius = data[RADIUS_BITS-1:0];
      REG_AMOUNT:   amount = data[AMOUNT_BITS-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_falloff(input logic [CFG_DATA_BITS-1:0] cx,
                             input logic [CFG_DATA_BITS-1:0] cy,
                             input logic [CFG_DATA_BITS-1:0] r,
                             input logic [CFG_DATA_BITS-1:0] a);
    drain_pipeline();
    write_reg(REG_CENTRE_X, cx);
    write_reg(REG_CENTRE_Y, cy);
    write_reg(REG_RADIUS, r);
    write_reg(REG_AMOUNT, a);
    settings_used++;
  endtask

  // With the reset settings the amount is zero, so every height passes through.
  task automatic test_reset_values();
    send_sample('0, '0, '0);
    send_sample(COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX), HEIGHT_MAX);
    send_sample('0, '0, HEIGHT_MAX);
    send_sample(COORD_BITS'(COORD_MAX), '0, 7'd64);
  endtask

  task automatic test_peak_and_clamp();
    set_falloff(15'd8192, 15'd8192, 15'd256, 15'd255);
    send_sample(10'd512, 10'd512, '0);
    send_sample(10'd528, 10'd512, 7'd100);
    send_sample(10'd524, 10'd512, '0);
    // The 9-bit pattern with only the sign bit set is the most negative amount.
    set_falloff(15'd8192, 15'd8192, 15'd256, 15'h0100);
    send_sample(10'd512, 10'd512, HEIGHT_MAX);
    send_sample(10'd524, 10'd512, 7'd100);
    send_sample(10'd513, 10'd512, HEIGHT_MAX);
    // An amount of -1 gives a small negative fraction that must truncate down.
    set_falloff(15'd8192, 15'd8192, 15'd256, 15'h7FFF);
    send_sample(10'd514, 10'd515, 7'd5);
    send_sample(10'd512, 10'd512, 7'd1);
  endtask

  task automatic test_register_edges();
    set_falloff(15'd8192, 15'd8192, 15'd0, 15'd255);
    send_sample(10'd512, 10'd512, 7'd50);
    send_sample(COORD_BITS'(COORD_MAX), '0, HEIGHT_MAX);
    // Centre data with the top bit set and the largest radius.
    set_falloff(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'd255);
    send_sample(COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX), 7'd3);
    send_sample('0, '0, '0);
    set_falloff(15'd1600, 15'd1600, 15'd1, 15'd255);
    send_sample(10'd100, 10'd100, 7'd10);
    send_sample(10'd101, 10'd100, 7'd10);
    drain_pipeline();
    for (int i = REG_AMOUNT + 1; i < (1 << CFG_INDEX_BITS); i++) begin
      write_reg(CFG_INDEX_BITS'(i), CFG_DATA_BITS'($urandom));
    end
    send_sample(10'd100, 10'd100, 7'd20);
  endtask

  task automatic test_random_settings();
    logic [CFG_DATA_BITS-1:0] r;
    logic [CFG_DATA_BITS-1:0] a;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [HEIGHT_BITS-1:0] h;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(9))
        0:       r = 15'd0;
        1:       r = 15'd1;
        2:       r = 15'd16384;
        3:       r = 15'h7FFF;
        4, 5:    r = CFG_DATA_BITS'($urandom_range(1, 64));
        default: r = CFG_DATA_BITS'($urandom_range(1, 4096));
      endcase
      case ($urandom_range(5))
        0:       a = 15'd255;
        1:       a = 15'h0100;
        default: a = CFG_DATA_BITS'($urandom);
      endcase
      set_falloff(CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom), r, a);
      if ($urandom_range(2) == 0)
        write_reg(CFG_INDEX_BITS'($urandom_range(REG_AMOUNT + 1, 7)),
                  CFG_DATA_BITS'($urandom));
      // The first phase runs back to back, one sample beat per cycle.
      allow_gaps = (phase != 0);
      for (int k = 0; k < PHASE_SAMPLES; k++) begin
        if (phase == 3 && k == PHASE_SAMPLES / 2) drain_pipeline();
        if ($urandom_range(99) < 75) begin
          x = near_coord(centre_x);
          y = near_coord(centre_y);
        end else begin
          x = COORD_BITS'($urandom);
          y = COORD_BITS'($urandom);
        end
        case ($urandom_range(7))
          0:       h = '0;
          1:       h = HEIGHT_MAX;
          default: h = HEIGHT_BITS'($urandom);
        endcase
        send_sample(x, y, h);
      end
    end
    allow_gaps = 1'b1;
  endtask

  always @(posedge clk) begin : check_results
    height_expect_t oldest;
    if (!rst && done) begin
      results_seen++;
      if (pending_heights.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, height_out=%0d", height_out));
      end else begin
        oldest = pending_heights.pop_front();
        if (height_out !== oldest.height)
          report_mismatch($sformatf("x=%0d y=%0d h=%0d: height_out=%0d, predicted %0d",
                                    oldest.x, oldest.y, oldest.h, height_out,
                                    oldest.height));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_peak_and_clamp();
    test_register_edges();
    test_random_settings();
    drain_pipeline();
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    $display("Checked %0d results from %0d samples under %0d settings (%0d register writes).",
             results_seen, samples_sent, settings_used, reg_writes);
    $display("Settings spanned zero, unit and oversized radius, both amount extremes and unused indexes.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
